FILE: hw/rtl/ptpt_pkg.sv
// ----------------------------------------------------------------------------
// Tune tracker package
// Shared widths, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ptpt_pkg;

   localparam int DEFAULT_PARTICLE_COUNT = 4096;
   localparam int DEFAULT_PHASE_BITS = 16;
   localparam int INDEX_WIDTH = 12;
   localparam int COORD_WIDTH = 24;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CORDIC_STEPS = 32;
   // u and v grow by less than a factor of 1.65 over the iterations.
   localparam int CORDIC_WIDTH = 27;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MATRIX_ROW0 = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MATRIX_ROW1 = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MATRIX_ROW2 = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MATRIX_ROW3 = 2'd3;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [CORDIC_WIDTH-1:0] cordic_type;

   function automatic logic [31:0] atan_turn(input logic [4:0] step);
      logic [31:0] t;
      case (step)
         5'd0: t = 32'h20000000;   5'd1: t = 32'h12E4051E;
         5'd2: t = 32'h09FB385B;   5'd3: t = 32'h051111D4;
         5'd4: t = 32'h028B0D43;   5'd5: t = 32'h0145D7E1;
         5'd6: t = 32'h00A2F61E;   5'd7: t = 32'h00517C55;
         5'd8: t = 32'h0028BE53;   5'd9: t = 32'h00145F2F;
         5'd10: t = 32'h000A2F98;  5'd11: t = 32'h000517CC;
         5'd12: t = 32'h00028BE6;  5'd13: t = 32'h000145F3;
         5'd14: t = 32'h0000A2FA;  5'd15: t = 32'h0000517D;
         5'd16: t = 32'h000028BE;  5'd17: t = 32'h0000145F;
         5'd18: t = 32'h00000A30;  5'd19: t = 32'h00000518;
         5'd20: t = 32'h0000028C;  5'd21: t = 32'h00000146;
         5'd22: t = 32'h000000A3;  5'd23: t = 32'h00000051;
         5'd24: t = 32'h00000029;  5'd25: t = 32'h00000014;
         5'd26: t = 32'h0000000A;  5'd27: t = 32'h00000005;
         5'd28: t = 32'h00000003;  5'd29: t = 32'h00000001;
         5'd30: t = 32'h00000001;  default: t = 32'h00000000;
      endcase
      return t;
   endfunction

endpackage

FILE: hw/rtl/particle_tune_phase_tracker.sv
// ----------------------------------------------------------------------------
// Particle tune phase tracker
// Normalizes four transverse coordinates, finds both plane phases and
// actions, and forms the tunes against each particle's stored phases.
// ----------------------------------------------------------------------------
// One transaction is taken per clock cycle while req_stall is low, and its
// result passes in order through the stages below into the output register;
// the pipeline advances whenever the output register is empty or being taken.
// The depth is set by the chain of 32 CORDIC cells, plus an input register, a
// product stage, a sum and saturate stage, a half-plane fold stage, a phase
// store read stage and the output register. After reset the phase store is
// cleared, during which req_stall is high.
module particle_tune_phase_tracker #(
   parameter int PARTICLE_COUNT = ptpt_pkg::DEFAULT_PARTICLE_COUNT,
   parameter int PHASE_BITS = ptpt_pkg::DEFAULT_PHASE_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [11:0] req_particle_index,
   input  logic signed [23:0] req_x_position,
   input  logic signed [23:0] req_x_angle,
   input  logic signed [23:0] req_y_position,
   input  logic signed [23:0] req_y_angle,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_phase_first,
   output logic [15:0] rsp_phase_second,
   output logic [15:0] rsp_tune_first,
   output logic [15:0] rsp_tune_second,
   output logic [47:0] rsp_action_first,
   output logic [47:0] rsp_action_second,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int AW = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;
   localparam int CW = ptpt_pkg::CORDIC_WIDTH;
   localparam int SIDE = AW + 96;
   localparam int NCELL = ptpt_pkg::CORDIC_STEPS;
   localparam int SH = 32 - PHASE_BITS;
   localparam logic [63:0] IDX_RECIP = ((64'd1 << 32) + 64'(PARTICLE_COUNT - 1))
                                       / 64'(PARTICLE_COUNT);

   typedef logic signed [39:0] prod_type;
   typedef logic signed [41:0] sum_type;

   logic [63:0] row_ff [4];
   logic clearing_ff;
   logic [AW:0] clear_count_ff;

   // Stage valid flags and the advance signal.
   logic adv;
   logic v0_ff, v1_ff, v2_ff, v3_ff;
   logic [NCELL:1] vc_ff;
   logic v5_ff, v6_ff;
   logic rv_ff;

   assign adv = !rv_ff || !rsp_stall;
   assign req_stall = !adv || clearing_ff;
   assign csr_ready = 1'b1;

   wire take = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= 64'h0000000000002000;
         row_ff[1] <= 64'h0000000020000000;
         row_ff[2] <= 64'h0000200000000000;
         row_ff[3] <= 64'h2000000000000000;
      end else if (csr_valid) begin
         unique case (csr_index)
            ptpt_pkg::REG_MATRIX_ROW0: row_ff[0] <= csr_data;
            ptpt_pkg::REG_MATRIX_ROW1: row_ff[1] <= csr_data;
            ptpt_pkg::REG_MATRIX_ROW2: row_ff[2] <= csr_data;
            ptpt_pkg::REG_MATRIX_ROW3: row_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // Stage 0: register the transaction and the index quotient.
   ptpt_pkg::coord_type c_ff [4];
   logic [11:0] idx0_ff;
   logic [11:0] quot0_ff;
   logic [44:0] idx_prod;
   assign idx_prod = 45'(req_particle_index) * 45'(IDX_RECIP);
   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else if (adv) v0_ff <= take;
      if (adv) begin
         c_ff[0] <= req_x_position;
         c_ff[1] <= req_x_angle;
         c_ff[2] <= req_y_position;
         c_ff[3] <= req_y_angle;
         idx0_ff <= req_particle_index;
         quot0_ff <= idx_prod[43:32];
      end
   end

   // Stage 1: sixteen products and the index modulo PARTICLE_COUNT.
   prod_type p_ff [4][4];
   logic [AW-1:0] idx1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= v0_ff;
      if (adv) begin
         idx1_ff <= AW'(idx0_ff - 12'(32'(quot0_ff) * PARTICLE_COUNT));
         for (int r = 0; r < 4; r++)
            for (int j = 0; j < 4; j++)
               p_ff[r][j] <= 40'(c_ff[j]) * 40'($signed(row_ff[r][16*j +: 16]));
      end
   end

   // Stage 2: sum, round and saturate.
   ptpt_pkg::coord_type n_ff [4];
   logic [AW-1:0] idx2_ff;
   sum_type s [4];
   sum_type sr [4];
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         s[r] = 42'(p_ff[r][0]) + 42'(p_ff[r][1]) + 42'(p_ff[r][2])
              + 42'(p_ff[r][3]) + 42'sd4096;
         sr[r] = s[r] >>> 13;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
      if (adv) begin
         idx2_ff <= idx1_ff;
         for (int r = 0; r < 4; r++) begin
            if (sr[r] > 42'sd8388607) n_ff[r] <= 24'sh7FFFFF;
            else if (sr[r] < -42'sd8388608) n_ff[r] <= 24'sh800000;
            else n_ff[r] <= sr[r][23:0];
         end
      end
   end

   // Stage 3: half-plane fold and zero detect; squares.
   ptpt_pkg::cordic_type u1_ff, w1_ff, u2_ff, w2_ff;
   logic [31:0] z1_ff, z2_ff;
   logic [47:0] sq_ff [4];
   logic [AW-1:0] idx3_ff;
   logic zero1_ff, zero2_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
      if (adv) begin
         idx3_ff <= idx2_ff;
         zero1_ff <= (n_ff[0] == '0) && (n_ff[1] == '0);
         zero2_ff <= (n_ff[2] == '0) && (n_ff[3] == '0);
         for (int r = 0; r < 4; r++)
            sq_ff[r] <= 48'(n_ff[r]) * 48'(n_ff[r]);
         if (n_ff[0][23]) begin
            u1_ff <= -CW'(n_ff[0]); w1_ff <= -CW'(n_ff[1]); z1_ff <= 32'h80000000;
         end else begin
            u1_ff <= CW'(n_ff[0]); w1_ff <= CW'(n_ff[1]); z1_ff <= '0;
         end
         if (n_ff[2][23]) begin
            u2_ff <= -CW'(n_ff[2]); w2_ff <= -CW'(n_ff[3]); z2_ff <= 32'h80000000;
         end else begin
            u2_ff <= CW'(n_ff[2]); w2_ff <= CW'(n_ff[3]); z2_ff <= '0;
         end
      end
   end

   // CORDIC chain. Actions are summed here and carried with the index.
   ptpt_pkg::cordic_type cu1 [NCELL+1], cv1 [NCELL+1], cu2 [NCELL+1], cv2 [NCELL+1];
   logic [31:0] cz1 [NCELL+1], cz2 [NCELL+1];
   logic [SIDE+1:0] cs [NCELL+1];

   assign cu1[0] = u1_ff;
   assign cv1[0] = w1_ff;
   assign cu2[0] = u2_ff;
   assign cv2[0] = w2_ff;
   assign cz1[0] = z1_ff;
   assign cz2[0] = z2_ff;
   assign cs[0] = {zero1_ff, zero2_ff, idx3_ff,
                   48'(sq_ff[0] + sq_ff[1]), 48'(sq_ff[2] + sq_ff[3])};

   for (genvar g = 0; g < NCELL; g++) begin : g_cell
      ptpt_cordic_cell #(.STEP(g), .SIDE_WIDTH(SIDE + 2)) u_cell (
         .clock(clock), .enable(adv),
         .u1_in(cu1[g]), .v1_in(cv1[g]), .u2_in(cu2[g]), .v2_in(cv2[g]),
         .z1_in(cz1[g]), .z2_in(cz2[g]), .side_in(cs[g]),
         .u1_out(cu1[g+1]), .v1_out(cv1[g+1]), .u2_out(cu2[g+1]), .v2_out(cv2[g+1]),
         .z1_out(cz1[g+1]), .z2_out(cz2[g+1]), .side_out(cs[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) vc_ff <= '0;
      else if (adv) vc_ff <= {vc_ff[NCELL-1:1], v3_ff};
   end

   // Stage 5: round the phases and read the store.
   logic [PHASE_BITS-1:0] store1 [PARTICLE_COUNT];
   logic [PHASE_BITS-1:0] store2 [PARTICLE_COUNT];
   logic [PHASE_BITS-1:0] ph1_5, ph2_5, ph1_ff, ph2_ff, old1_ff, old2_ff;
   logic [AW-1:0] idx5_ff;
   logic [95:0] act5_ff;
   logic [SIDE+1:0] side_end;
   logic [32:0] r1, r2;

   assign side_end = cs[NCELL];
   always_comb begin
      if (SH == 0) begin
         r1 = {1'b0, cz1[NCELL]};
         r2 = {1'b0, cz2[NCELL]};
      end else begin
         r1 = (33'(cz1[NCELL]) + (33'd1 << (SH - 1))) >> SH;
         r2 = (33'(cz2[NCELL]) + (33'd1 << (SH - 1))) >> SH;
      end
      ph1_5 = side_end[SIDE+1] ? '0 : r1[PHASE_BITS-1:0];
      ph2_5 = side_end[SIDE] ? '0 : r2[PHASE_BITS-1:0];
   end

   // Newest store writes forward to a following read of the same index.
   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic [PHASE_BITS-1:0] wr1, wr2;
   wire [AW-1:0] rd_addr = side_end[SIDE-1:96];
   wire fwd = v6_ff && (idx5_ff == rd_addr);

   assign wr_en = clearing_ff || (adv && v6_ff);
   assign wr_addr = clearing_ff ? clear_count_ff[AW-1:0] : idx5_ff;
   assign wr1 = clearing_ff ? '0 : ph1_ff;
   assign wr2 = clearing_ff ? '0 : ph2_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store1[wr_addr] <= wr1;
         store2[wr_addr] <= wr2;
      end
      if (adv) begin
         old1_ff <= fwd ? ph1_ff : store1[rd_addr];
         old2_ff <= fwd ? ph2_ff : store2[rd_addr];
         ph1_ff <= ph1_5;
         ph2_ff <= ph2_5;
         idx5_ff <= rd_addr;
         act5_ff <= side_end[95:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clear_count_ff <= '0;
      end else if (clearing_ff) begin
         clear_count_ff <= clear_count_ff + 1'b1;
         if (clear_count_ff == (AW + 1)'(PARTICLE_COUNT - 1)) clearing_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= vc_ff[NCELL];
         v6_ff <= vc_ff[NCELL];
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (adv) rv_ff <= v5_ff;
      if (adv) begin
         rsp_phase_first <= 16'(ph1_ff);
         rsp_phase_second <= 16'(ph2_ff);
         rsp_tune_first <= 16'(PHASE_BITS'(old1_ff - ph1_ff));
         rsp_tune_second <= 16'(PHASE_BITS'(old2_ff - ph2_ff));
         rsp_action_first <= act5_ff[95:48];
         rsp_action_second <= act5_ff[47:0];
      end
   end

   assign rsp_valid = rv_ff;

endmodule

FILE: hw/rtl/ptpt_cordic_cell.sv
// ----------------------------------------------------------------------------
// CORDIC cell
// One registered vectoring rotation of both planes, with the payload that
// travels alongside.
// ----------------------------------------------------------------------------
module ptpt_cordic_cell #(
   parameter int STEP = 0,
   parameter int SIDE_WIDTH = 1
) (
   input  logic                       clock,
   input  logic                       enable,
   input  ptpt_pkg::cordic_type       u1_in, v1_in, u2_in, v2_in,
   input  logic [31:0]                z1_in, z2_in,
   input  logic [SIDE_WIDTH-1:0]      side_in,
   output ptpt_pkg::cordic_type       u1_out, v1_out, u2_out, v2_out,
   output logic [31:0]                z1_out, z2_out,
   output logic [SIDE_WIDTH-1:0]      side_out
);

   localparam logic [31:0] ANGLE = ptpt_pkg::atan_turn(5'(STEP));

   ptpt_pkg::cordic_type u1_ff, v1_ff, u2_ff, v2_ff;
   ptpt_pkg::cordic_type u1_in_n, v1_in_n, u2_in_n, v2_in_n;
   logic [31:0] z1_ff, z2_ff, z1_in_n, z2_in_n;
   logic [SIDE_WIDTH-1:0] side_ff;

   always_comb begin
      if (!v1_in[ptpt_pkg::CORDIC_WIDTH-1]) begin
         u1_in_n = u1_in + (v1_in >>> STEP);
         v1_in_n = v1_in - (u1_in >>> STEP);
         z1_in_n = z1_in + ANGLE;
      end else begin
         u1_in_n = u1_in - (v1_in >>> STEP);
         v1_in_n = v1_in + (u1_in >>> STEP);
         z1_in_n = z1_in - ANGLE;
      end
      if (!v2_in[ptpt_pkg::CORDIC_WIDTH-1]) begin
         u2_in_n = u2_in + (v2_in >>> STEP);
         v2_in_n = v2_in - (u2_in >>> STEP);
         z2_in_n = z2_in + ANGLE;
      end else begin
         u2_in_n = u2_in - (v2_in >>> STEP);
         v2_in_n = v2_in + (u2_in >>> STEP);
         z2_in_n = z2_in - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         u1_ff <= u1_in_n;
         v1_ff <= v1_in_n;
         u2_ff <= u2_in_n;
         v2_ff <= v2_in_n;
         z1_ff <= z1_in_n;
         z2_ff <= z2_in_n;
         side_ff <= side_in;
      end
   end

   assign u1_out = u1_ff;
   assign v1_out = v1_ff;
   assign u2_out = u2_ff;
   assign v2_out = v2_ff;
   assign z1_out = z1_ff;
   assign z2_out = z2_ff;
   assign side_out = side_ff;

endmodule
